// ===== hw/rtl/pptc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pptc_pkg: shared types and constants for the pre/post trigger capture ring
// Sizes, request and result codes, and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pptc_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int TRIG_W     = 8;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int NB_W       = $clog2(DEPTH + 1);
   localparam int WIN_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_DRAIN  = 2'd1,
      REQ_FLUSH  = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_STORED  = 2'd0,
      KIND_OVERRUN = 2'd1,
      KIND_EMIT    = 2'd2,
      KIND_DONE    = 2'd3
   } kind_code_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BUFFERS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_TRIGGER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_TRIGGER = 2'd2;

   typedef struct packed {
      logic latch;
      logic sample;
      logic drain_step;
      logic flush_step;
      logic finish;
      logic clr_pre_count;
   } cmd_type;

   typedef struct packed {
      logic drain_more;
      logic flush_more;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pre_post_trigger_capture_ring.sv =====
`default_nettype none
// Sample: the target slot is read when the request is latched, ahead of its
//   write in the sample state; requests are taken only in idle.
// Drain/flush: one step per visited slot (at most num_buffers), then the done
//   result; emitted slots appear in the cycle after their visit.
// Synchronous reset: marks clear, pointers reset, stored records undefined.
// The result receiver cannot stall; each result is valid for one cycle.
// ----------------------------------------------------------------------------
// pre_post_trigger_capture_ring: trigger capture ring, top level
// Joins the request sequencer and the ring datapath.
// ----------------------------------------------------------------------------
module pre_post_trigger_capture_ring
   import pptc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_type,
   input  wire logic [DATA_WIDTH-1:0] req_sample_data,
   input  wire logic [TRIG_W-1:0]     req_trigger_byte,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_kind,
   output logic [DATA_WIDTH-1:0]      rsp_out_data,
   output logic [TRIG_W-1:0]          rsp_out_trigger,
   output logic [SLOT_W-1:0]          rsp_slot_index,
   output logic                       rsp_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   pptc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   pptc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample_data  (req_sample_data),
      .req_trigger_byte (req_trigger_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_trigger  (rsp_out_trigger),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/pptc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pptc_ctrl: request sequencer
// Accepts a transaction, then steps the datapath through the sample, drain
// walk, flush walk or pre-count clear, ending each request with its result.
// ----------------------------------------------------------------------------
module pptc_ctrl
   import pptc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] req_type,
   input  status_type      status,
   output logic            busy,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_DRAIN,
      ST_FLUSH,
      ST_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               case (req_code_type'(req_type))
                  REQ_SAMPLE: state_in = ST_SAMPLE;
                  REQ_DRAIN:  state_in = ST_DRAIN;
                  REQ_FLUSH:  state_in = ST_FLUSH;
                  REQ_CLEAR:  state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SAMPLE: begin
            cmd.sample = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_DRAIN: begin
            if (status.drain_more) begin
               cmd.drain_step = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.flush_more) begin
               cmd.flush_step = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.finish        = 1'b1;
            cmd.clr_pre_count = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pptc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pptc_dp: capture ring datapath
// Holds the configuration, the record/trigger memory, the keep marks and the
// ring pointers, and drives the registered result ports.
// ----------------------------------------------------------------------------
module pptc_dp
   import pptc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [DATA_WIDTH-1:0] req_sample_data,
   input  wire logic [TRIG_W-1:0]     req_trigger_byte,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_kind,
   output logic [DATA_WIDTH-1:0]      rsp_out_data,
   output logic [TRIG_W-1:0]          rsp_out_trigger,
   output logic [SLOT_W-1:0]          rsp_slot_index,
   output logic                       rsp_last
);

   function automatic logic [NB_W-1:0] eff_nb(input logic [CSR_DATA_W-1:0] raw);
      logic [NB_W-1:0] res;
      if (raw == '0) begin
         res = NB_W'(1);
      end else if (int'(raw) > DEPTH) begin
         res = NB_W'(DEPTH);
      end else begin
         res = NB_W'(raw);
      end
      return res;
   endfunction

   function automatic logic [WIN_W-1:0] eff_pre(input logic [WIN_W-1:0] raw,
                                                input logic [NB_W-1:0]  nb);
      logic [WIN_W-1:0] res;
      if (NB_W'(raw) > nb - NB_W'(1)) begin
         res = WIN_W'(nb - NB_W'(1));
      end else begin
         res = raw;
      end
      return res;
   endfunction

   // configuration
   logic [CSR_DATA_W-1:0] nb_raw_ff, nb_raw_in;
   logic [WIN_W-1:0]      pre_raw_ff, pre_raw_in;
   logic [WIN_W-1:0]      post_raw_ff, post_raw_in;

   // ring state
   logic [SLOT_W-1:0]     wp_ff;
   logic [NB_W-1:0]       rp_ff;
   logic                  armed_ff;
   logic [WIN_W-1:0]      post_cnt_ff;
   logic [WIN_W-1:0]      pwc_ff;
   logic [DEPTH-1:0]      marks_ff, marks_in;

   // walk state and latched request
   logic [SLOT_W-1:0]     walk_ff;
   logic [NB_W-1:0]       count_ff;
   logic [DATA_WIDTH-1:0] req_data_ff;
   logic [TRIG_W-1:0]     req_trig_ff;

   // memory and its read registers
   logic [DATA_WIDTH-1:0] rec_mem [DEPTH];
   logic [TRIG_W-1:0]     trig_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_rec_ff;
   logic [TRIG_W-1:0]     rd_trig_ff;

   // result registers
   logic                  rsp_strobe_ff;
   kind_code_type         rsp_kind_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic                  rsp_last_ff;
   logic                  show_ff;

   logic                  cfg_restart;
   logic [NB_W-1:0]       new_nb;
   logic [WIN_W-1:0]      new_pre;
   logic [NB_W-1:0]       rp_restart;

   logic [NB_W-1:0]       nb;
   logic [WIN_W-1:0]      pre;
   logic                  nb1;
   logic [SLOT_W-1:0]     wp_adv;
   logic [NB_W:0]         stop_sum;
   logic [NB_W-1:0]       stop;
   logic [SLOT_W-1:0]     cur;
   logic [SLOT_W-1:0]     cur_adv;
   logic [SLOT_W-1:0]     walk_adv;
   logic [SLOT_W-1:0]     drain_slot;
   logic [NB_W-1:0]       rp_next;
   logic [SLOT_W-1:0]     rd_addr;
   logic [SLOT_W-1:0]     emit_slot;
   logic                  emit_hit;
   logic                  overrun;
   logic                  trig;
   logic [WIN_W-1:0]      lim;
   logic [DEPTH-1:0]      pre_hit;
   logic [NB_W:0]         back_sum;
   logic [NB_W:0]         back_gap;

   // configuration writes restart the ring from the new values
   always_comb begin
      nb_raw_in   = nb_raw_ff;
      pre_raw_in  = pre_raw_ff;
      post_raw_in = post_raw_ff;
      cfg_restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_BUFFERS: begin
               nb_raw_in   = csr_wdata;
               cfg_restart = 1'b1;
            end
            CSR_PRE_TRIGGER: begin
               pre_raw_in  = WIN_W'(csr_wdata);
               cfg_restart = 1'b1;
            end
            CSR_POST_TRIGGER: begin
               post_raw_in = WIN_W'(csr_wdata);
               cfg_restart = 1'b1;
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
      new_nb  = eff_nb(nb_raw_in);
      new_pre = eff_pre(pre_raw_in, new_nb);
      if (new_pre == '0) begin
         rp_restart = new_nb - NB_W'(1);
      end else begin
         rp_restart = new_nb - NB_W'(new_pre);
      end
   end

   always_comb begin
      nb  = eff_nb(nb_raw_ff);
      pre = eff_pre(pre_raw_ff, nb);
      nb1 = (nb == NB_W'(1));

      wp_adv = (NB_W'(wp_ff) + NB_W'(1) == nb) ? '0 : wp_ff + SLOT_W'(1);

      // drain stops pre slots short of the write pointer
      stop_sum = (NB_W+1)'(wp_ff) + (NB_W+1)'(nb) - (NB_W+1)'(pre);
      if (stop_sum >= (NB_W+1)'(nb)) begin
         stop = NB_W'(stop_sum - (NB_W+1)'(nb));
      end else begin
         stop = NB_W'(stop_sum);
      end

      cur        = (rp_ff >= nb) ? '0 : rp_ff[SLOT_W-1:0];
      cur_adv    = (NB_W'(cur) + NB_W'(1) == nb) ? '0 : cur + SLOT_W'(1);
      walk_adv   = (NB_W'(walk_ff) + NB_W'(1) == nb) ? '0 : walk_ff + SLOT_W'(1);
      drain_slot = nb1 ? '0 : cur;
      rp_next    = nb1 ? NB_W'(1) : NB_W'(cur_adv);

      status.drain_more = nb1 ? (count_ff == '0)
                              : ((count_ff < nb) && (NB_W'(cur) != stop));
      status.flush_more = (count_ff < nb);

      if (cmd.drain_step) begin
         rd_addr = drain_slot;
      end else if (cmd.flush_step) begin
         rd_addr = walk_ff;
      end else begin
         rd_addr = wp_ff;
      end

      emit_slot = cmd.drain_step ? drain_slot : walk_ff;
      emit_hit  = (cmd.drain_step || cmd.flush_step) && marks_ff[emit_slot];

      // an overrun keeps the old entry, so its trigger byte decides
      overrun = marks_ff[wp_ff];
      trig    = overrun ? (rd_trig_ff != '0) : (req_trig_ff != '0);
      lim     = (pre < pwc_ff) ? pre : pwc_ff;

      // slots 1..lim behind the write pointer, modulo the ring size
      pre_hit = '0;
      for (int s = 0; s < DEPTH; s++) begin
         back_sum = (NB_W+1)'(wp_ff) + (NB_W+1)'(nb) - (NB_W+1)'(s);
         if (back_sum >= (NB_W+1)'(nb)) begin
            back_gap = back_sum - (NB_W+1)'(nb);
         end else begin
            back_gap = back_sum;
         end
         pre_hit[s] = ((NB_W+1)'(s) < (NB_W+1)'(nb)) && (back_gap != '0)
                      && (back_gap <= (NB_W+1)'(lim));
      end

      marks_in = marks_ff;
      if (cfg_restart) begin
         marks_in = '0;
      end else if (cmd.sample) begin
         marks_in[wp_ff] = trig;
         if (trig) begin
            if (!armed_ff) begin
               marks_in = marks_in | pre_hit;
            end
         end else if (post_cnt_ff != '0) begin
            marks_in[wp_ff] = 1'b1;
         end
      end else if (emit_hit) begin
         marks_in[emit_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_raw_ff     <= CSR_DATA_W'(DEPTH);
         pre_raw_ff    <= '0;
         post_raw_ff   <= '0;
         wp_ff         <= '0;
         rp_ff         <= NB_W'(DEPTH - 1);
         armed_ff      <= 1'b0;
         post_cnt_ff   <= '0;
         pwc_ff        <= '0;
         marks_ff      <= '0;
         walk_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_kind_ff   <= KIND_DONE;
         rsp_slot_ff   <= '0;
         rsp_last_ff   <= 1'b0;
         show_ff       <= 1'b0;
      end else begin
         nb_raw_ff     <= nb_raw_in;
         pre_raw_ff    <= pre_raw_in;
         post_raw_ff   <= post_raw_in;
         marks_ff      <= marks_in;
         rsp_strobe_ff <= cmd.sample || emit_hit || cmd.finish;
         show_ff       <= emit_hit;

         if (cfg_restart) begin
            wp_ff       <= '0;
            rp_ff       <= rp_restart;
            armed_ff    <= 1'b0;
            post_cnt_ff <= '0;
            pwc_ff      <= '0;
         end

         if (cmd.latch) begin
            walk_ff  <= wp_ff;
            count_ff <= '0;
         end

         if (cmd.sample) begin
            if (trig) begin
               armed_ff    <= 1'b1;
               post_cnt_ff <= post_raw_ff;
            end else begin
               armed_ff <= 1'b0;
               if (post_cnt_ff != '0) begin
                  post_cnt_ff <= post_cnt_ff - WIN_W'(1);
               end
            end
            if (pwc_ff < pre) begin
               pwc_ff <= pwc_ff + WIN_W'(1);
            end
            wp_ff         <= wp_adv;
            rsp_kind_ff   <= overrun ? KIND_OVERRUN : KIND_STORED;
            rsp_slot_ff   <= wp_ff;
            rsp_last_ff   <= 1'b1;
         end

         if (cmd.drain_step) begin
            rp_ff    <= rp_next;
            count_ff <= count_ff + NB_W'(1);
         end

         if (cmd.flush_step) begin
            walk_ff  <= walk_adv;
            count_ff <= count_ff + NB_W'(1);
         end

         if (emit_hit) begin
            rsp_kind_ff   <= KIND_EMIT;
            rsp_slot_ff   <= emit_slot;
            rsp_last_ff   <= 1'b0;
         end

         if (cmd.finish) begin
            rsp_kind_ff   <= KIND_DONE;
            rsp_slot_ff   <= '0;
            rsp_last_ff   <= 1'b1;
         end

         if (cmd.clr_pre_count) begin
            pwc_ff <= '0;
         end
      end
   end

   // latch the request payload when the transaction is taken
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_data_ff <= req_sample_data;
         req_trig_ff <= req_trigger_byte;
      end
   end

   // record and trigger memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.sample && !overrun) begin
         rec_mem[wp_ff]  <= req_data_ff;
         trig_mem[wp_ff] <= req_trig_ff;
      end
      rd_rec_ff  <= rec_mem[rd_addr];
      rd_trig_ff <= trig_mem[rd_addr];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_data    = show_ff ? rd_rec_ff : '0;
   assign rsp_out_trigger = show_ff ? rd_trig_ff : '0;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

// ===== tb/sv/pre_post_trigger_capture_ring_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pre_post_trigger_capture_ring_tb: self-checking bench for the capture ring
// Drives sample, drain, flush and pre-count clear transactions through the
// command port, predicts every result with a behavioral copy of the ring, and
// compares each strobed result field by field against the oldest prediction.
// Ring settings are changed between phases, extremes and saturation included.
// ----------------------------------------------------------------------------
module pre_post_trigger_capture_ring_tb;
   import pptc_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 6;
   localparam int TAIL_CYCLES  = 40;
   localparam int SHOW_LIMIT   = 10;
   localparam int PHASE_ITEMS  = 27;

   typedef struct {
      kind_code_type         kind;
      logic [DATA_WIDTH-1:0] data;
      logic [TRIG_W-1:0]     trig;
      logic [SLOT_W-1:0]     slot;
      logic                  last;
   } ring_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_type;
   logic [DATA_WIDTH-1:0] req_sample_data;
   logic [TRIG_W-1:0]     req_trigger_byte;
   logic                  rsp_strobe;
   logic [1:0]            rsp_kind;
   logic [DATA_WIDTH-1:0] rsp_out_data;
   logic [TRIG_W-1:0]     rsp_out_trigger;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic                  rsp_last;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // ring prediction state
   logic [DATA_WIDTH-1:0] ring_record [DEPTH];
   logic [TRIG_W-1:0]     ring_trigger [DEPTH];
   logic [DEPTH-1:0]      ring_keep;
   int unsigned           ring_wptr;
   int unsigned           ring_rptr;
   int unsigned           ring_post_left;
   int unsigned           ring_pre_count;
   bit                    ring_armed;
   logic [NB_W-1:0]       cfg_num_buffers;
   logic [WIN_W-1:0]      cfg_pre_trigger;
   logic [WIN_W-1:0]      cfg_post_trigger;

   ring_result_type pending_results[$];
   ring_result_type want;

   int  mismatches;
   int  results_checked;
   int  requests_sent;
   int  settings_used;
   int  cycle_count;
   int  burst_left;
   bit  trigger_level;

   pre_post_trigger_capture_ring uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_sample_data  (req_sample_data),
      .req_trigger_byte (req_trigger_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_trigger  (rsp_out_trigger),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned ring_size();
      if (cfg_num_buffers == 0) return 1;
      if (cfg_num_buffers > DEPTH) return DEPTH;
      return cfg_num_buffers;
   endfunction

   function automatic int unsigned pre_window();
      int unsigned nb;
      nb = ring_size();
      return (cfg_pre_trigger > nb - 1) ? nb - 1 : cfg_pre_trigger;
   endfunction

   task automatic restart_ring();
      int unsigned nb;
      int unsigned pre;
      nb  = ring_size();
      pre = pre_window();
      ring_keep      = '0;
      ring_wptr      = 0;
      ring_rptr      = (pre == 0) ? nb - 1 : nb - pre;
      ring_armed     = 1'b0;
      ring_post_left = 0;
      ring_pre_count = 0;
   endtask

   task automatic push_result(kind_code_type kind, logic [DATA_WIDTH-1:0] data,
                              logic [TRIG_W-1:0] trig, int unsigned slot, logic last);
      ring_result_type r;
      r.kind = kind;
      r.data = data;
      r.trig = trig;
      r.slot = SLOT_W'(slot);
      r.last = last;
      pending_results.push_back(r);
   endtask

   task automatic emit_kept_slot(int unsigned s);
      if (ring_keep[s]) begin
         push_result(KIND_EMIT, ring_record[s], ring_trigger[s], s, 1'b0);
         ring_keep[s] = 1'b0;
      end
   endtask

   task automatic predict_ring_results(req_code_type req, logic [DATA_WIDTH-1:0] data,
                                       logic [TRIG_W-1:0] trig);
      int unsigned nb;
      int unsigned pre;
      int unsigned w;
      int unsigned stop;
      int unsigned idx;
      int unsigned i;
      int unsigned j;
      bit          overrun;
      bit          hit;
      nb  = ring_size();
      pre = pre_window();
      if (ring_wptr >= nb) ring_wptr = 0;
      if (req == REQ_SAMPLE) begin
         w = ring_wptr;
         overrun = ring_keep[w];
         // keep the old contents of a slot that is still marked
         if (!overrun) begin
            ring_record[w]  = data;
            ring_trigger[w] = trig;
         end
         hit = (ring_trigger[w] != 0);
         ring_keep[w] = hit;
         if (hit) begin
            if (!ring_armed) begin
               ring_armed = 1'b1;
               for (j = 0; j < pre; j++) begin
                  if (j < ring_pre_count) ring_keep[(w + nb - j - 1) % nb] = 1'b1;
               end
            end
            ring_post_left = cfg_post_trigger;
         end else begin
            if (ring_post_left > 0) begin
               ring_keep[w] = 1'b1;
               ring_post_left--;
            end
            ring_armed = 1'b0;
         end
         if (ring_pre_count < pre) ring_pre_count++;
         ring_wptr = (w + 1 == nb) ? 0 : w + 1;
         push_result(overrun ? KIND_OVERRUN : KIND_STORED, '0, '0, w, 1'b1);
      end else begin
         case (req)
            REQ_DRAIN: begin
               if (nb == 1) begin
                  emit_kept_slot(0);
                  ring_rptr = 1;
               end else begin
                  stop = (ring_wptr + nb - pre) % nb;
                  if (ring_rptr >= nb) ring_rptr = 0;
                  for (i = 0; i < nb && ring_rptr != stop; i++) begin
                     emit_kept_slot(ring_rptr);
                     ring_rptr = (ring_rptr + 1 == nb) ? 0 : ring_rptr + 1;
                  end
               end
            end
            REQ_FLUSH: begin
               idx = ring_wptr;
               for (i = 0; i < nb; i++) begin
                  emit_kept_slot(idx);
                  idx = (idx + 1 == nb) ? 0 : idx + 1;
               end
            end
            default: ring_pre_count = 0;
         endcase
         push_result(KIND_DONE, '0, '0, 0, 1'b1);
      end
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= SHOW_LIMIT) $display("Mismatch: %s", what);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind=%0d data=%h trig=%h slot=%0d last=%b",
                                      rsp_kind, rsp_out_data, rsp_out_trigger,
                                      rsp_slot_index, rsp_last));
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind || rsp_out_data !== want.data ||
                rsp_out_trigger !== want.trig || rsp_slot_index !== want.slot ||
                rsp_last !== want.last) begin
               report_mismatch($sformatf(
                  "exp kind=%0d data=%h trig=%h slot=%0d last=%b, got kind=%0d data=%h trig=%h slot=%0d last=%b",
                  want.kind, want.data, want.trig, want.slot, want.last,
                  rsp_kind, rsp_out_data, rsp_out_trigger, rsp_slot_index, rsp_last));
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving
   // Call at a rising edge; start stays high so back-to-back transactions chain.
   task automatic send_request(req_code_type req, logic [DATA_WIDTH-1:0] data,
                               logic [TRIG_W-1:0] trig);
      start            <= 1'b1;
      req_type         <= req;
      req_sample_data  <= data;
      req_trigger_byte <= trig;
      do @(posedge clock); while (busy !== 1'b0);
      predict_ring_results(req, data, trig);
      requests_sent++;
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drop start and let every outstanding result arrive
   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_NUM_BUFFERS:  cfg_num_buffers  = value[NB_W-1:0];
         CSR_PRE_TRIGGER:  cfg_pre_trigger  = value[WIN_W-1:0];
         CSR_POST_TRIGGER: cfg_post_trigger = value[WIN_W-1:0];
         default: ;
      endcase
      restart_ring();
      @(posedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] nb, logic [CSR_DATA_W-1:0] pre,
                            logic [CSR_DATA_W-1:0] post);
      wait_quiet();
      write_reg(CSR_NUM_BUFFERS, nb);
      write_reg(CSR_PRE_TRIGGER, pre);
      write_reg(CSR_POST_TRIGGER, post);
      settings_used++;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_defaults();
      send_request(REQ_SAMPLE, 32'h0000_0000, 8'h01);
      send_request(REQ_SAMPLE, 32'hFFFF_FFFF, 8'h00);
      send_request(REQ_DRAIN, '0, '0);
      send_request(REQ_FLUSH, '0, '0);
   endtask

   task automatic test_trigger_windows();
      int k;
      configure(5'd8, 5'd2, 5'd2);
      send_request(REQ_SAMPLE, 32'h0000_0000, 8'h00);
      send_request(REQ_SAMPLE, 32'hFFFF_FFFF, 8'h00);
      send_request(REQ_SAMPLE, 32'hA5A5_5A5A, 8'h00);
      // rising edge pulls in the two earlier slots
      send_request(REQ_SAMPLE, 32'h1234_5678, 8'h01);
      send_request(REQ_SAMPLE, 32'h8765_4321, 8'h80);
      send_request(REQ_SAMPLE, 32'hDEAD_BEEF, 8'h00);
      send_request(REQ_SAMPLE, 32'hCAFE_F00D, 8'h00);
      send_request(REQ_SAMPLE, 32'h0F0F_0F0F, 8'h00);
      send_request(REQ_DRAIN, '0, '0);
      send_request(REQ_SAMPLE, 32'hF0F0_F0F0, 8'h00);
      send_request(REQ_DRAIN, '0, '0);
      send_request(REQ_FLUSH, '0, '0);
      send_request(REQ_CLEAR, '0, '0);
      // fill every slot with a trigger, then wrap onto marked slots
      for (k = 0; k < 9; k++) send_request(REQ_SAMPLE, 32'h5000_0000 + k, 8'hFF);
      send_request(REQ_SAMPLE, 32'h7777_7777, 8'h00);
      send_request(REQ_FLUSH, '0, '0);
   endtask

   task automatic test_single_slot();
      // pre window saturates to zero in a one-slot ring
      configure(5'd1, 5'd15, 5'd3);
      send_request(REQ_SAMPLE, 32'h1111_1111, 8'h02);
      send_request(REQ_SAMPLE, 32'h2222_2222, 8'h00);
      send_request(REQ_DRAIN, '0, '0);
      send_request(REQ_SAMPLE, 32'h3333_3333, 8'h00);
      send_request(REQ_DRAIN, '0, '0);
      send_request(REQ_FLUSH, '0, '0);
   endtask

   task automatic random_sample();
      logic [DATA_WIDTH-1:0] data;
      logic [TRIG_W-1:0]     trig;
      int                    pick;
      pick = $urandom_range(0, 9);
      data = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
      if ($urandom_range(0, 4) == 0) trigger_level = ~trigger_level;
      if (!trigger_level) trig = 8'h00;
      else if ($urandom_range(0, 5) == 0) trig = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h80;
      else trig = TRIG_W'($urandom_range(1, 255));
      send_request(REQ_SAMPLE, data, trig);
   endtask

   task automatic run_random_phase(int count, bit gaps_on);
      int n;
      int pick;
      burst_left = 0;
      for (n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            if (gaps_on) hold_off($urandom_range(1, 9));
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
         pick = $urandom_range(0, 99);
         if (pick < 70) random_sample();
         else if (pick < 84) send_request(REQ_DRAIN, $urandom, TRIG_W'($urandom));
         else if (pick < 92) send_request(REQ_FLUSH, $urandom, TRIG_W'($urandom));
         else send_request(REQ_CLEAR, $urandom, TRIG_W'($urandom));
      end
   endtask

   task automatic test_random_settings();
      int p;
      configure(5'd16, 5'd15, 5'd15);
      run_random_phase(PHASE_ITEMS, 1'b1);
      configure(5'd16, 5'd0, 5'd0);
      run_random_phase(PHASE_ITEMS, 1'b0);
      configure(5'd31, 5'd3, 5'd5);
      run_random_phase(PHASE_ITEMS, 1'b1);
      configure(5'd0, 5'd2, 5'd1);
      run_random_phase(PHASE_ITEMS, 1'b1);
      for (p = 0; p < 3; p++) begin
         configure(CSR_DATA_W'($urandom_range(2, 16)), CSR_DATA_W'($urandom_range(0, 31)),
                   CSR_DATA_W'($urandom_range(0, 31)));
         run_random_phase(PHASE_ITEMS, p != 1);
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = REQ_SAMPLE;
      req_sample_data  = '0;
      req_trigger_byte = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_NUM_BUFFERS;
      csr_wdata        = '0;
      mismatches       = 0;
      results_checked  = 0;
      requests_sent    = 0;
      settings_used    = 1;
      cycle_count      = 0;
      trigger_level    = 1'b0;
      for (int s = 0; s < DEPTH; s++) begin
         ring_record[s]  = '0;
         ring_trigger[s] = '0;
      end
      cfg_num_buffers  = NB_W'(DEPTH);
      cfg_pre_trigger  = '0;
      cfg_post_trigger = '0;
      restart_ring();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_reset_defaults();
      test_trigger_windows();
      test_single_slot();
      test_random_settings();

      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      $display("Sent %0d requests across %0d ring settings; checked %0d results.",
               requests_sent, settings_used, results_checked);
      $display("Mismatches counted: %0d", mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
